>>> rtl/core/nr_pkg.sv
// Shared types, constants and tables of the nutation rotation block.
package nr_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_EPS  = 2'd0;
  localparam logic [1:0] REG_DPSI = 2'd1;
  localparam logic [1:0] REG_DEPS = 2'd2;

  // Reset values of the configuration registers (radians times 2^40).
  localparam logic signed [42:0] EPS_RESET  = 43'sd449664530935;
  localparam logic signed [34:0] DPSI_RESET = 35'sd0;
  localparam logic signed [34:0] DEPS_RESET = 35'sd0;

  // CORDIC constants in Q2.30.
  localparam int unsigned CORDIC_STEPS = 32;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sh026DD3B6A;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;

  // Unity in Q.40 and the output clamp in Q1.30.
  localparam logic signed [47:0] Q40_ONE = 48'sd1099511627776;
  localparam logic signed [31:0] OUT_MAX = 32'sd1073741824;

  // Slots of the intermediate product store.
  localparam logic [3:0] P_MU = 4'd0;
  localparam logic [3:0] P_NU = 4'd1;
  localparam logic [3:0] P_SE = 4'd2;
  localparam logic [3:0] P_DD = 4'd3;
  localparam logic [3:0] P_MM = 4'd4;
  localparam logic [3:0] P_NN = 4'd5;
  localparam logic [3:0] P_EN = 4'd6;
  localparam logic [3:0] P_EM = 4'd7;
  localparam logic [3:0] P_MN = 4'd8;

  // Matrix build sequencer states.
  typedef enum logic [2:0] {
    B_LOAD,
    B_CORDIC,
    B_MSTART,
    B_MWAIT,
    B_DONE,
    B_IDLE
  } build_state_t;

  // Request to the sequential multiplier.
  typedef struct packed {
    logic               start;
    logic signed [35:0] a;
    logic signed [35:0] b;
  } mul_req_t;

  // Truncated arctangent of 2^-i in Q.30.
  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'h3243F6A8;
        5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;
        5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;
        5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;
        5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;
        5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;
        5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;
        5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;
        5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;
        5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;
        5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;
        5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;
        5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;
        5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;
        5'd27: v = 32'h00000008;
        5'd28: v = 32'h00000004;
        5'd29: v = 32'h00000002;
        5'd30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      atan_q30 = $signed({4'd0, v});
    end
  endfunction

endpackage

>>> rtl/core/nr_mul_seq.sv
// Shift-and-add signed multiplier, one multiplier bit per cycle.
module nr_mul_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  nr_pkg::mul_req_t   req,
  output logic               done,
  output logic signed [71:0] prod
);

  logic        busy_r, done_r, neg_r;
  logic [5:0]  cnt_r;
  logic [71:0] acc_r, mcand_r;
  logic [35:0] mplier_r;
  logic [35:0] a_mag, b_mag;
  logic [71:0] acc_nxt;

  // Magnitudes of the operands.
  assign a_mag   = req.a[35] ? 36'(-req.a) : 36'(req.a);
  assign b_mag   = req.b[35] ? 36'(-req.b) : 36'(req.b);
  assign acc_nxt = mplier_r[0] ? acc_r + mcand_r : acc_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd35) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Accumulator and shifting operands.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= '0;
      mcand_r  <= {36'd0, a_mag};
      mplier_r <= b_mag;
      neg_r    <= req.a[35] ^ req.b[35];
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[70:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[35:1]};
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

>>> rtl/core/nr_mat_build.sv
// Configuration registers and the sequencer that rebuilds the nutation matrix.
module nr_mat_build #(
  parameter int CFB = 30,
  parameter int W   = CFB + 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [42:0]      cfg_data,
  output logic             idle,
  output logic [9*W-1:0]   matrix
);

  localparam int SH = 41 - CFB;

  nr_pkg::build_state_t state_r, state_nxt;
  logic signed [42:0] eps_r;
  logic signed [34:0] dpsi_r, deps_r;
  logic signed [35:0] x_r, y_r, z_r, cos_v, sin_v;
  logic               flip_r;
  logic [4:0]         step_r;
  logic [3:0]         k_r;
  logic signed [47:0] prod_r [9];
  logic [W-1:0]       mat_r [9];

  logic               cfg_hit;
  logic signed [43:0] eps_rnd;
  logic signed [35:0] z0, xs, ys, atan_v, dpsi36, deps36, mu36, nu36;
  nr_pkg::mul_req_t   req;
  logic               mul_start;
  logic               mul_done;
  logic signed [71:0] mul_p, r30, r40;
  logic signed [47:0] m [9];
  logic signed [47:0] t;

  assign cfg_hit = cfg_valid && idle &&
                   (cfg_index == nr_pkg::REG_EPS || cfg_index == nr_pkg::REG_DPSI ||
                    cfg_index == nr_pkg::REG_DEPS);
  assign idle    = (state_r == nr_pkg::B_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= nr_pkg::EPS_RESET;
      dpsi_r <= nr_pkg::DPSI_RESET;
      deps_r <= nr_pkg::DEPS_RESET;
    end else if (cfg_valid && idle) begin
      unique case (cfg_index)
        nr_pkg::REG_EPS:  eps_r  <= cfg_data;
        nr_pkg::REG_DPSI: dpsi_r <= cfg_data[34:0];
        nr_pkg::REG_DEPS: deps_r <= cfg_data[34:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= nr_pkg::B_LOAD;
    else        state_r <= state_nxt;
  end

  // Next state and multiplier start.
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    unique case (state_r)
      nr_pkg::B_LOAD:   state_nxt = nr_pkg::B_CORDIC;
      nr_pkg::B_CORDIC: if (step_r == 5'(nr_pkg::CORDIC_STEPS - 1)) begin
        state_nxt = nr_pkg::B_MSTART;
      end
      nr_pkg::B_MSTART: begin
        mul_start = 1'b1;
        state_nxt = nr_pkg::B_MWAIT;
      end
      nr_pkg::B_MWAIT:  if (mul_done) begin
        state_nxt = (k_r == nr_pkg::P_MN) ? nr_pkg::B_DONE : nr_pkg::B_MSTART;
      end
      nr_pkg::B_DONE:   state_nxt = nr_pkg::B_IDLE;
      nr_pkg::B_IDLE:   if (cfg_hit) state_nxt = nr_pkg::B_LOAD;
      default:          state_nxt = nr_pkg::B_IDLE;
    endcase
  end

  // Angle rounded to Q.30 and folded into the right half plane.
  assign eps_rnd = ($signed({eps_r[42], eps_r}) + 44'sd512) >>> 10;
  assign z0      = 36'(eps_rnd);
  assign xs      = x_r >>> step_r;
  assign ys      = y_r >>> step_r;
  assign atan_v  = nr_pkg::atan_q30(step_r);

  // CORDIC rotation, one step a cycle, and storage of each finished product.
  always_ff @(posedge clk) begin
    unique case (state_r)
      nr_pkg::B_LOAD: begin
        x_r    <= nr_pkg::CORDIC_GAIN;
        y_r    <= '0;
        step_r <= '0;
        k_r    <= nr_pkg::P_MU;
        if (z0 > nr_pkg::Q30_HALF_PI) begin
          z_r    <= z0 - nr_pkg::Q30_PI;
          flip_r <= 1'b1;
        end else if (z0 < -nr_pkg::Q30_HALF_PI) begin
          z_r    <= z0 + nr_pkg::Q30_PI;
          flip_r <= 1'b1;
        end else begin
          z_r    <= z0;
          flip_r <= 1'b0;
        end
      end
      nr_pkg::B_CORDIC: begin
        step_r <= step_r + 5'd1;
        if (!z_r[35]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_v;
        end
      end
      nr_pkg::B_MWAIT: if (mul_done) begin
        prod_r[k_r] <= (k_r < nr_pkg::P_SE) ? 48'(r30) : 48'(r40);
        k_r         <= k_r + 4'd1;
      end
      default: ;
    endcase
  end

  // Cosine and sine with the fold undone.
  assign cos_v = flip_r ? -x_r : x_r;
  assign sin_v = flip_r ? -y_r : y_r;

  // Operand selection for each product of the build.
  assign dpsi36 = {dpsi_r[34], dpsi_r};
  assign deps36 = {deps_r[34], deps_r};
  assign mu36   = 36'(prod_r[nr_pkg::P_MU]);
  assign nu36   = 36'(prod_r[nr_pkg::P_NU]);
  always_comb begin
    req.start = mul_start;
    unique case (k_r)
      nr_pkg::P_MU: begin req.a = dpsi36; req.b = cos_v;  end
      nr_pkg::P_NU: begin req.a = dpsi36; req.b = sin_v;  end
      nr_pkg::P_SE: begin req.a = deps36; req.b = deps36; end
      nr_pkg::P_DD: begin req.a = dpsi36; req.b = dpsi36; end
      nr_pkg::P_MM: begin req.a = mu36;   req.b = mu36;   end
      nr_pkg::P_NN: begin req.a = nu36;   req.b = nu36;   end
      nr_pkg::P_EN: begin req.a = deps36; req.b = nu36;   end
      nr_pkg::P_EM: begin req.a = deps36; req.b = mu36;   end
      nr_pkg::P_MN: begin req.a = mu36;   req.b = nu36;   end
      default:      begin req.a = '0;     req.b = '0;     end
    endcase
  end

  nr_mul_seq u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .done (mul_done),
    .prod (mul_p)
  );

  // Products rounded half up to Q.40.
  assign r30 = (mul_p + 72'sd536870912) >>> 30;
  assign r40 = (mul_p + 72'sd549755813888) >>> 40;

  // Second-order matrix entries in Q.40.
  always_comb begin
    t    = -((prod_r[nr_pkg::P_MN] + 48'sd1) >>> 1);
    m[0] = nr_pkg::Q40_ONE - ((prod_r[nr_pkg::P_DD] + 48'sd1) >>> 1);
    m[1] = -prod_r[nr_pkg::P_MU];
    m[2] = -prod_r[nr_pkg::P_NU];
    m[3] = prod_r[nr_pkg::P_MU] - prod_r[nr_pkg::P_EN];
    m[4] = nr_pkg::Q40_ONE -
           ((prod_r[nr_pkg::P_SE] - prod_r[nr_pkg::P_MM] + 48'sd1) >>> 1);
    m[5] = t - 48'(deps_r);
    m[6] = prod_r[nr_pkg::P_NU] - prod_r[nr_pkg::P_EM];
    m[7] = t + 48'(deps_r);
    m[8] = nr_pkg::Q40_ONE -
           ((prod_r[nr_pkg::P_SE] + prod_r[nr_pkg::P_NN] + 48'sd1) >>> 1);
  end

  // Entries rounded to the stored fraction width.
  always_ff @(posedge clk) begin
    if (state_r == nr_pkg::B_DONE) begin
      for (int i = 0; i < 9; i++) begin
        mat_r[i] <= W'(({m[i], 1'b0} + (49'sd1 <<< (SH - 1))) >>> SH);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) matrix[i*W +: W] = mat_r[i];
  end

endmodule

>>> rtl/core/nr_vec_pipe.sv
// Four-stage pipeline that multiplies a vector by the stored matrix.
module nr_vec_pipe #(
  parameter int CFB = 30,
  parameter int W   = CFB + 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [9*W-1:0]     matrix,
  output logic               out_valid,
  output logic [95:0]        out_data
);

  localparam int PW = 32 + W;
  localparam int SW = PW + 2;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] vec_r [3];
  logic signed [PW-1:0] prd_r [9];
  logic signed [SW-1:0] sum_r [3];
  logic [31:0]          res_r [3];
  logic signed [SW-1:0] shf [3];

  // Valid bits advance together under the stall enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r} <= '0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Payload stages: capture, products, row sums, round and clamp.
  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r[0] <= in_x;
      vec_r[1] <= in_y;
      vec_r[2] <= in_z;
      for (int i = 0; i < 9; i++) begin
        prd_r[i] <= $signed(matrix[i*W +: W]) * vec_r[i % 3];
      end
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= SW'(prd_r[3*r]) + SW'(prd_r[3*r+1]) + SW'(prd_r[3*r+2]) +
                    (SW'(1) <<< (CFB - 1));
      end
      for (int r = 0; r < 3; r++) begin
        if (shf[r] > SW'(nr_pkg::OUT_MAX))       res_r[r] <= nr_pkg::OUT_MAX;
        else if (shf[r] < -SW'(nr_pkg::OUT_MAX)) res_r[r] <= -nr_pkg::OUT_MAX;
        else                                     res_r[r] <= 32'(shf[r]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) shf[r] = sum_r[r] >>> CFB;
  end

  assign out_valid = v4_r;
  assign out_data  = {res_r[2], res_r[1], res_r[0]};

endmodule

>>> rtl/core/nutation_rotation.sv
// Top level of the approximate nutation matrix rotation.
// Each accepted request is registered through the capture, product, row-sum and clamp stages to out_tdata.
// Throughput: one vector per cycle while no rebuild runs; the output register stalls the whole pipeline.
// Matrix rebuild runs a load, 32 CORDIC steps, nine sequential products and a store.
// Synchronous active-low reset restores the registers and starts a rebuild;
// in_tready and cfg_ready stay low until the matrix is ready.
module nutation_rotation #(
  parameter int COSINE_FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // mean_x [31:0], mean_y [63:32], mean_z [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // true_x [31:0], true_y [63:32], true_z [95:64]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [42:0] cfg_data
);

  localparam int W = COSINE_FRAC_BITS + 4;

  logic           idle, adv;
  logic [9*W-1:0] matrix;

  // Pipeline moves whenever the output register is free or being taken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && idle;
  assign cfg_ready = idle;

  nr_mat_build #(.CFB(COSINE_FRAC_BITS), .W(W)) u_build (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .idle     (idle),
    .matrix   (matrix)
  );

  nr_vec_pipe #(.CFB(COSINE_FRAC_BITS), .W(W)) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid && in_tready),
    .in_x     (in_tdata[31:0]),
    .in_y     (in_tdata[63:32]),
    .in_z     (in_tdata[95:64]),
    .matrix   (matrix),
    .out_valid(out_tvalid),
    .out_data (out_tdata)
  );

endmodule

>>> rtl/core/nr_checker.sv
// Port-level checks of the nutation rotation block and their binding.
module nr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [42:0] cfg_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset starts a rebuild, so nothing is taken in the next cycle.
  a_reset_build: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !cfg_ready)
    else $error("requests taken straight after reset");

  // A register write starts a rebuild that blocks input.
  a_cfg_build: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index != nr_pkg::REG_DEPS + 2'd1 |=>
      !in_tready && !cfg_ready)
    else $error("input taken during matrix rebuild");

  // Every result component lies within plus or minus one.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      $signed(out_tdata[31:0])  <= nr_pkg::OUT_MAX &&
      $signed(out_tdata[31:0])  >= -nr_pkg::OUT_MAX &&
      $signed(out_tdata[63:32]) <= nr_pkg::OUT_MAX &&
      $signed(out_tdata[63:32]) >= -nr_pkg::OUT_MAX &&
      $signed(out_tdata[95:64]) <= nr_pkg::OUT_MAX &&
      $signed(out_tdata[95:64]) >= -nr_pkg::OUT_MAX)
    else $error("result outside saturation range");

  // Input is only taken with the matrix ready.
  a_ready_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> cfg_ready)
    else $error("input ready while matrix busy");

endmodule

bind nutation_rotation nr_checker u_nr_checker (.*);
